// ===== sv/hra_pkg.sv =====
// ----------------------------------------------------------------------------
// hra_pkg: shared definitions for the heart rate averager
// Widths, reset values, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package hra_pkg;

   // Ring of recent accepted rates.
   localparam int RATE_SLOTS = 4;
   localparam int RATE_W     = 8;
   localparam int SLOT_IDX_W = (RATE_SLOTS > 1) ? $clog2(RATE_SLOTS) : 1;

   // Running sum and count over the ring.
   localparam int SUM_W         = $clog2(RATE_SLOTS * (2**RATE_W - 1) + 1);
   localparam int VALID_COUNT_W = 3;
   localparam int CNT_RAW_W     = $clog2(RATE_SLOTS + 1);
   localparam int CNT_W         = (CNT_RAW_W > VALID_COUNT_W) ? CNT_RAW_W : VALID_COUNT_W;

   // Beat timing and the shared divider.
   localparam int TIME_W        = 32;
   localparam int BEAT_RATE_W   = 16;
   localparam int DIV_W         = 16;
   localparam int DIVISOR_W     = 32;
   localparam int DIV_STEP_W    = $clog2(DIV_W + 1);
   localparam logic [DIV_W-1:0] MS_PER_MINUTE = 16'd60000;

   // Result beat layout.
   localparam int RSP_TDATA_W = 32;
   localparam int RSP_PAD_W   = RSP_TDATA_W - BEAT_RATE_W - 1 - RATE_W - VALID_COUNT_W;

   // Configuration registers.
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RATE = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RATE = 8'd1;
   localparam logic [RATE_W-1:0]    MIN_RATE_RESET = 8'd40;
   localparam logic [RATE_W-1:0]    MAX_RATE_RESET = 8'd200;

   // Item kinds carried in req_tuser.
   localparam logic MODE_BEAT = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_RATE,
      ST_SWEEP,
      ST_DIV_AVG,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// ===== sv/hra_div.sv =====
// ----------------------------------------------------------------------------
// hra_div: shared restoring divider
// Unsigned 16-bit dividend over a 32-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module hra_div
   import hra_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DIV_W-1:0]     dividend,
   input  wire logic [DIVISOR_W-1:0] divisor,
   output logic                      done,
   output logic [DIV_W-1:0]          quotient
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_STEP_W-1:0] step_ff, step_in;
   logic [DIV_W-1:0]      dvd_ff, dvd_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;

   logic [DIVISOR_W:0]    rem_sh;
   logic                  fits;

   // The partial remainder stays below the divisor, so one extra bit suffices.
   assign rem_sh = {rem_ff, dvd_ff[DIV_W-1]};
   assign fits   = rem_sh >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = dividend;
         rem_in  = '0;
         dvs_in  = divisor;
      end else if (busy_ff) begin
         dvd_in  = {dvd_ff[DIV_W-2:0], fits};
         rem_in  = fits ? DIVISOR_W'(rem_sh - {1'b0, dvs_ff}) : rem_sh[DIVISOR_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == DIV_STEP_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = dvd_ff;

endmodule

`default_nettype wire

// ===== sv/hra_ring.sv =====
// ----------------------------------------------------------------------------
// hra_ring: ring of recent accepted beat rates
// Writes go to a rotating slot; one slot is read at a time for the sweep.
// ----------------------------------------------------------------------------
`default_nettype none

module hra_ring
   import hra_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  wr_en,
   input  wire logic [RATE_W-1:0]     wr_data,
   input  wire logic [SLOT_IDX_W-1:0] rd_idx,
   output logic      [RATE_W-1:0]     rd_data
);

   logic [RATE_W-1:0]     slots_ff [RATE_SLOTS];
   logic [SLOT_IDX_W-1:0] wr_slot_ff, wr_slot_in;

   always_comb begin
      wr_slot_in = wr_slot_ff;
      if (wr_en) begin
         if (wr_slot_ff == SLOT_IDX_W'(RATE_SLOTS - 1)) begin
            wr_slot_in = '0;
         end else begin
            wr_slot_in = wr_slot_ff + 1'b1;
         end
      end
   end

   // An empty slot holds zero, which the average skips.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_slot_ff <= '0;
         for (int i = 0; i < RATE_SLOTS; i++) begin
            slots_ff[i] <= '0;
         end
      end else begin
         wr_slot_ff <= wr_slot_in;
         if (wr_en) begin
            slots_ff[wr_slot_ff] <= wr_data;
         end
      end
   end

   assign rd_data = slots_ff[rd_idx];

endmodule

`default_nettype wire

// ===== sv/heart_rate_averager.sv =====
// ----------------------------------------------------------------------------
// heart_rate_averager: beat intervals to a moving average of beats per minute
// Beats give 60000 / interval, stored when inside the rate bounds; every item
// returns the floor mean and count of the nonzero stored rates.
// ----------------------------------------------------------------------------
//   Channel   Direction   Payload
//   req_      in          tuser: mode; tdata: time_ms
//   rsp_      out         tdata: beat_rate, accepted, average_rate, valid_count
//   csr_      in          index: register number; data: register value
//
// Each item runs on one shared restoring divider that produces one quotient
// bit per cycle, used for the beat rate and again for the average, plus a
// sweep of one ring slot per cycle. Reports and zero intervals skip the rate
// division. Reset is synchronous and clears the ring, the beat reference and
// the bounds to 40 and 200.
// A stalled result is held in the output register; the next item is taken
// once the sequencer is back in idle.
// ----------------------------------------------------------------------------
`default_nettype none

module heart_rate_averager
   import hra_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [TIME_W-1:0]      req_tdata,   // [31:0] time_ms
   input  wire logic                   req_tuser,   // [0] mode
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [15:0] beat_rate, [16] accepted, [24:17] average_rate, [27:25] valid_count
   output logic [RSP_TDATA_W-1:0]      rsp_tdata,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_data
);

   state_type state_ff, state_in;

   logic [RATE_W-1:0]      min_rate_ff, max_rate_ff;
   logic [TIME_W-1:0]      last_time_ff, last_time_in;
   logic [BEAT_RATE_W-1:0] rate_ff, rate_in;
   logic                   acc_ff, acc_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [SLOT_IDX_W-1:0]  idx_ff, idx_in;
   logic [RATE_W-1:0]      avg_ff, avg_in;
   logic                   rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_TDATA_W-1:0] rsp_tdata_ff;

   logic                   req_fire;
   logic [TIME_W-1:0]      interval;
   logic                   beat_div;
   logic                   in_range;
   logic [RATE_W-1:0]      ring_rd;
   logic [SUM_W-1:0]       sum_add;
   logic [CNT_W-1:0]       cnt_add;
   logic                   sweep_last;
   logic                   out_free;

   logic                   div_start;
   logic [DIV_W-1:0]       div_dividend;
   logic [DIVISOR_W-1:0]   div_divisor;
   logic                   div_done;
   logic [DIV_W-1:0]       div_quot;
   logic                   ring_wr;
   logic                   rsp_load;

   // --------------------------------------------------------------------------
   // Shared units
   // --------------------------------------------------------------------------
   hra_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quot)
   );

   hra_ring u_ring (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (ring_wr),
      .wr_data (div_quot[RATE_W-1:0]),
      .rd_idx  (idx_ff),
      .rd_data (ring_rd)
   );

   // --------------------------------------------------------------------------
   // Conditions
   // --------------------------------------------------------------------------
   assign req_fire   = req_tvalid && req_tready;
   assign interval   = req_tdata - last_time_ff;
   assign beat_div   = (req_tuser == MODE_BEAT) && (interval != '0);
   assign in_range   = (div_quot > DIV_W'(min_rate_ff)) && (div_quot < DIV_W'(max_rate_ff));
   assign sum_add    = sum_ff + SUM_W'(ring_rd);
   assign cnt_add    = cnt_ff + CNT_W'(ring_rd != '0);
   assign sweep_last = idx_ff == SLOT_IDX_W'(RATE_SLOTS - 1);
   assign out_free   = !rsp_tvalid_ff || rsp_tready;

   // The divider is loaded either with the rate division or the average.
   assign div_dividend = (state_ff == ST_IDLE) ? MS_PER_MINUTE : DIV_W'(sum_add);
   assign div_divisor  = (state_ff == ST_IDLE) ? interval : DIVISOR_W'(cnt_add);

   // --------------------------------------------------------------------------
   // Sequencer
   // --------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = beat_div ? ST_DIV_RATE : ST_SWEEP;
            end
         end
         ST_DIV_RATE: begin
            if (div_done) begin
               state_in = ST_SWEEP;
            end
         end
         ST_SWEEP: begin
            if (sweep_last) begin
               state_in = (cnt_add == '0) ? ST_FINISH : ST_DIV_AVG;
            end
         end
         ST_DIV_AVG: begin
            if (div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      div_start  = 1'b0;
      ring_wr    = 1'b0;
      rsp_load   = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            div_start  = req_tvalid && beat_div;
         end
         ST_DIV_RATE: begin
            ring_wr = div_done && in_range;
         end
         ST_SWEEP: begin
            div_start = sweep_last && (cnt_add != '0);
         end
         ST_DIV_AVG: begin
         end
         ST_FINISH: begin
            rsp_load = out_free;
         end
         default: begin
         end
      endcase
   end

   // --------------------------------------------------------------------------
   // Datapath
   // --------------------------------------------------------------------------
   always_comb begin
      last_time_in = last_time_ff;
      rate_in      = rate_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      avg_in       = avg_ff;
      case (state_ff)
         ST_IDLE: begin
            rate_in = '0;
            acc_in  = 1'b0;
            sum_in  = '0;
            cnt_in  = '0;
            idx_in  = '0;
            avg_in  = '0;
            // A beat always becomes the new reference, even at zero interval.
            if (req_fire && (req_tuser == MODE_BEAT)) begin
               last_time_in = req_tdata;
            end
         end
         ST_DIV_RATE: begin
            if (div_done) begin
               rate_in = div_quot;
               acc_in  = in_range;
            end
         end
         ST_SWEEP: begin
            sum_in = sum_add;
            cnt_in = cnt_add;
            if (!sweep_last) begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DIV_AVG: begin
            if (div_done) begin
               avg_in = div_quot[RATE_W-1:0];
            end
         end
         ST_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (rsp_load) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_tvalid_ff <= 1'b0;
         last_time_ff  <= '0;
         min_rate_ff   <= MIN_RATE_RESET;
         max_rate_ff   <= MAX_RATE_RESET;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         last_time_ff  <= last_time_in;
         if (csr_valid && (csr_index == CSR_MIN_RATE)) begin
            min_rate_ff <= csr_data;
         end
         if (csr_valid && (csr_index == CSR_MAX_RATE)) begin
            max_rate_ff <= csr_data;
         end
      end
      rate_ff <= rate_in;
      acc_ff  <= acc_in;
      sum_ff  <= sum_in;
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      avg_ff  <= avg_in;
      if (rsp_load) begin
         rsp_tdata_ff <= {{RSP_PAD_W{1'b0}}, cnt_ff[VALID_COUNT_W-1:0], avg_ff,
                          acc_ff, rate_ff};
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // --------------------------------------------------------------------------
   // Assertions
   // --------------------------------------------------------------------------
   a_acc_in_bounds: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) && acc_ff |->
         (rate_ff > BEAT_RATE_W'(min_rate_ff)) && (rate_ff < BEAT_RATE_W'(max_rate_ff)))
      else $error("stored beat rate lies outside the bounds");

   a_avg_matches_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> ((avg_ff == '0) == (cnt_ff == '0)))
      else $error("average and count disagree on an empty ring");

   a_count_limit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH) |-> (cnt_ff <= CNT_W'(RATE_SLOTS)))
      else $error("count of stored rates exceeds the ring size");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIV_RATE) || (state_ff == ST_DIV_AVG))
      else $error("divider finished outside a division state");

endmodule

`default_nettype wire
